@@ hdl/rlv_pkg.sv @@
package rlv_pkg;

  localparam int MAX_DESCRIPTORS = 64;
  localparam int MAX_EXPECTED    = 32;

  localparam int DESC_AW = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int DESC_CW = $clog2(MAX_DESCRIPTORS + 1);
  localparam int SEEN_AW = (MAX_EXPECTED > 1) ? $clog2(MAX_EXPECTED) : 1;
  localparam int SEEN_CW = $clog2(MAX_EXPECTED + 1);

  // Header size is one word per descriptor plus the leading word.
  localparam int HDR_WORD_BYTES = 4;
  localparam int HDR_W          = 19;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DESC = 2'd1,
    KIND_ATTR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_SMALL_BUF   = 4'd1,
    ERR_HDR_OVF     = 4'd2,
    ERR_ZERO_REC    = 4'd3,
    ERR_REC_OVF     = 4'd4,
    ERR_DESC_OFS    = 4'd5,
    ERR_MISSING_REQ = 4'd6,
    ERR_ATTR_OUT    = 4'd7,
    ERR_OVERLAP     = 4'd8,
    ERR_TABLE_FULL  = 4'd9,
    ERR_LIST_FULL   = 4'd10
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DLOOK,
    ST_ACHK,
    ST_SLOOK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] buffer_size;
    logic [31:0] record_count;
    logic [15:0] entry_count;
    logic [15:0] record_bytes;
  } hdr_fields_t;

  typedef struct packed {
    logic [15:0] hash;
    logic [15:0] offset;
  } desc_ent_t;

  typedef struct packed {
    logic [15:0] beg;
    logic [15:0] len;
  } seen_ent_t;

endpackage

@@ hdl/rlv_ram.sv @@
module rlv_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/rlv_hdr_chk.sv @@
module rlv_hdr_chk (
  input  logic                clk,
  input  logic                start,
  input  rlv_pkg::hdr_fields_t hdr,
  output rlv_pkg::err_t       code
);
  import rlv_pkg::*;

  logic [HDR_W-1:0] hdr_bytes;
  logic             small_r;
  logic             hovf_r;
  logic             zrec_r;
  logic [47:0]      prod_r;
  logic [31:0]      room_r;

  assign hdr_bytes = {1'b0, hdr.entry_count, 2'b00} + HDR_W'(HDR_WORD_BYTES);

  // Register the bound terms and the size product; decide on the next cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      small_r <= hdr.buffer_size < 32'(HDR_WORD_BYTES);
      hovf_r  <= 32'(hdr_bytes) > hdr.buffer_size;
      zrec_r  <= (hdr.record_count != 32'd0) && (hdr.record_bytes == 16'd0);
      prod_r  <= 48'(hdr.record_count) * 48'(hdr.record_bytes);
      room_r  <= hdr.buffer_size - 32'(hdr_bytes);
    end
  end

  always_comb begin
    priority if (small_r) begin
      code = ERR_SMALL_BUF;
    end else if (hovf_r) begin
      code = ERR_HDR_OVF;
    end else if (zrec_r) begin
      code = ERR_ZERO_REC;
    end else if (prod_r > 48'(room_r)) begin
      code = ERR_REC_OVF;
    end else begin
      code = ERR_NONE;
    end
  end

endmodule

@@ hdl/record_layout_validator_core.sv @@
// Flow: header beat via ST_HDR, descriptor and unknown beats straight to ST_FIN;
//   attribute beat scans in ST_DLOOK, then on a hit ST_ACHK and ST_SLOOK, to ST_FIN.
// Throughput: one beat at a time; the descriptor scan and the attribute scan each
//   read one memory entry per cycle, so attribute cost grows with both fill counts.
// Reset: synchronous active-low rst_n clears fill counts, record size, sticky error
//   and handshake state; memory contents are left as they are and never read unwritten.
module record_layout_validator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_buffer_size,
  input  logic [31:0] in_record_count,
  input  logic [15:0] in_entry_count,
  input  logic [15:0] in_record_bytes,
  input  logic [15:0] in_name_hash,
  input  logic [15:0] in_field_offset,
  input  logic [31:0] in_field_bytes,
  input  logic        in_required,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [3:0]  out_error_code,
  output logic        out_found,
  output logic [15:0] out_found_offset
);
  import rlv_pkg::*;

  // Keep the first failure only.
  function automatic err_t flag_err(err_t cur, err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  // Control state
  state_t             state_r, state_nxt;
  logic [DESC_CW-1:0] desc_fill_r, desc_fill_nxt;
  logic [SEEN_CW-1:0] seen_fill_r, seen_fill_nxt;
  logic [15:0]        rec_bytes_r, rec_bytes_nxt;
  logic               rec_present_r, rec_present_nxt;
  err_t               sticky_r, sticky_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Working payload of the beat in flight
  logic [15:0]        hash_r, hash_nxt;
  logic [31:0]        len_r, len_nxt;
  logic               req_r, req_nxt;
  logic [15:0]        beg_r, beg_nxt;
  logic [DESC_CW-1:0] didx_r, didx_nxt;
  logic [SEEN_CW-1:0] sidx_r, sidx_nxt;
  logic               found_r, found_nxt;
  err_t               out_err_r, out_err_nxt;
  logic               out_found_r, out_found_nxt;
  logic [15:0]        out_off_r, out_off_nxt;

  // Memory ports
  logic               d_we, d_re;
  logic [DESC_AW-1:0] d_waddr, d_raddr;
  desc_ent_t          d_wdata, d_rdata;
  logic               s_we, s_re;
  logic [SEEN_AW-1:0] s_waddr, s_raddr;
  seen_ent_t          s_wdata, s_rdata;

  // Header check
  logic               hdr_start;
  hdr_fields_t        hdr_in;
  err_t               hdr_code;

  logic               accept;
  logic [16:0]        new_end;
  logic [16:0]        old_end;
  logic               overlap;
  logic               fits;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign hdr_in.buffer_size  = in_buffer_size;
  assign hdr_in.record_count = in_record_count;
  assign hdr_in.entry_count  = in_entry_count;
  assign hdr_in.record_bytes = in_record_bytes;

  // Overlap of the candidate span with the stored span read last cycle.
  assign new_end = {1'b0, beg_r} + {1'b0, len_r[15:0]};
  assign old_end = {1'b0, s_rdata.beg} + {1'b0, s_rdata.len};
  assign overlap = ({1'b0, beg_r} < old_end) && ({1'b0, s_rdata.beg} < new_end);
  assign fits = (beg_r <= rec_bytes_r) && (len_r <= 32'(rec_bytes_r - beg_r));

  rlv_ram #(.DEPTH(MAX_DESCRIPTORS), .WIDTH($bits(desc_ent_t))) u_desc_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .re   (d_re),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  rlv_ram #(.DEPTH(MAX_EXPECTED), .WIDTH($bits(seen_ent_t))) u_seen_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .re   (s_re),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rlv_hdr_chk u_hdr_chk (
    .clk  (clk),
    .start(hdr_start),
    .hdr  (hdr_in),
    .code (hdr_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      desc_fill_r   <= '0;
      seen_fill_r   <= '0;
      rec_bytes_r   <= '0;
      rec_present_r <= 1'b0;
      sticky_r      <= ERR_NONE;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      desc_fill_r   <= desc_fill_nxt;
      seen_fill_r   <= seen_fill_nxt;
      rec_bytes_r   <= rec_bytes_nxt;
      rec_present_r <= rec_present_nxt;
      sticky_r      <= sticky_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r      <= hash_nxt;
    len_r       <= len_nxt;
    req_r       <= req_nxt;
    beg_r       <= beg_nxt;
    didx_r      <= didx_nxt;
    sidx_r      <= sidx_nxt;
    found_r     <= found_nxt;
    out_err_r   <= out_err_nxt;
    out_found_r <= out_found_nxt;
    out_off_r   <= out_off_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    desc_fill_nxt   = desc_fill_r;
    seen_fill_nxt   = seen_fill_r;
    rec_bytes_nxt   = rec_bytes_r;
    rec_present_nxt = rec_present_r;
    sticky_nxt      = sticky_r;
    pend_nxt        = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    hash_nxt        = hash_r;
    len_nxt         = len_r;
    req_nxt         = req_r;
    beg_nxt         = beg_r;
    didx_nxt        = didx_r;
    sidx_nxt        = sidx_r;
    found_nxt       = found_r;
    out_err_nxt     = out_err_r;
    out_found_nxt   = out_found_r;
    out_off_nxt     = out_off_r;

    d_we      = 1'b0;
    d_waddr   = desc_fill_r[DESC_AW-1:0];
    d_wdata   = '{hash: in_name_hash, offset: in_field_offset};
    d_re      = 1'b0;
    d_raddr   = didx_r[DESC_AW-1:0];
    s_we      = 1'b0;
    s_waddr   = seen_fill_r[SEEN_AW-1:0];
    s_wdata   = '{beg: beg_r, len: len_r[15:0]};
    s_re      = 1'b0;
    s_raddr   = sidx_r[SEEN_AW-1:0];
    hdr_start = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          found_nxt = 1'b0;
          beg_nxt   = '0;
          hash_nxt  = in_name_hash;
          len_nxt   = in_field_bytes;
          req_nxt   = in_required;
          didx_nxt  = '0;
          sidx_nxt  = '0;
          state_nxt = ST_FIN;
          unique case (in_kind)
            KIND_HDR: begin
              // Start a new check: drop both tables and the sticky error.
              desc_fill_nxt   = '0;
              seen_fill_nxt   = '0;
              sticky_nxt      = ERR_NONE;
              rec_bytes_nxt   = in_record_bytes;
              rec_present_nxt = (in_record_count != 32'd0);
              hdr_start       = 1'b1;
              state_nxt       = ST_HDR;
            end
            KIND_DESC: begin
              if (desc_fill_r >= DESC_CW'(MAX_DESCRIPTORS)) begin
                sticky_nxt = flag_err(sticky_r, ERR_TABLE_FULL);
              end else begin
                d_we          = 1'b1;
                desc_fill_nxt = desc_fill_r + 1'b1;
                if (in_field_offset > rec_bytes_r) begin
                  sticky_nxt = flag_err(sticky_r, ERR_DESC_OFS);
                end
              end
            end
            KIND_ATTR: begin
              state_nxt = ST_DLOOK;
            end
            default: begin
              // Unknown kind: report status only.
            end
          endcase
        end
      end

      ST_HDR: begin
        sticky_nxt = hdr_code;
        state_nxt  = ST_FIN;
      end

      ST_DLOOK: begin
        // Issue one read per cycle; compare the entry read last cycle.
        priority if (pend_r && (d_rdata.hash == hash_r)) begin
          found_nxt = 1'b1;
          beg_nxt   = d_rdata.offset;
          state_nxt = ST_ACHK;
        end else if (didx_r < desc_fill_r) begin
          d_re     = 1'b1;
          pend_nxt = 1'b1;
          didx_nxt = didx_r + 1'b1;
        end else begin
          if (req_r && rec_present_r) begin
            sticky_nxt = flag_err(sticky_r, ERR_MISSING_REQ);
          end
          state_nxt = ST_FIN;
        end
      end

      ST_ACHK: begin
        if (fits) begin
          state_nxt = ST_SLOOK;
        end else begin
          sticky_nxt = flag_err(sticky_r, ERR_ATTR_OUT);
          state_nxt  = ST_FIN;
        end
      end

      ST_SLOOK: begin
        priority if (pend_r && overlap) begin
          sticky_nxt = flag_err(sticky_r, ERR_OVERLAP);
          state_nxt  = ST_FIN;
        end else if (sidx_r < seen_fill_r) begin
          s_re     = 1'b1;
          pend_nxt = 1'b1;
          sidx_nxt = sidx_r + 1'b1;
        end else begin
          if (seen_fill_r >= SEEN_CW'(MAX_EXPECTED)) begin
            sticky_nxt = flag_err(sticky_r, ERR_LIST_FULL);
          end else begin
            s_we          = 1'b1;
            seen_fill_nxt = seen_fill_r + 1'b1;
          end
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // Load the output register once the previous beat has left.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = sticky_r;
          out_found_nxt = found_r;
          out_off_nxt   = found_r ? beg_r : 16'd0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = (out_err_r == ERR_NONE);
  assign out_error_code   = out_err_r;
  assign out_found        = out_found_r;
  assign out_found_offset = out_off_r;

  a_desc_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    desc_fill_r <= DESC_CW'(MAX_DESCRIPTORS))
    else $error("descriptor fill beyond table depth");

  a_seen_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_fill_r <= SEEN_CW'(MAX_EXPECTED))
    else $error("attribute fill beyond list depth");

  a_hdr_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_HDR)) |=> (state_r == ST_HDR) && (desc_fill_r == '0))
    else $error("header beat did not clear table");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_offset == 16'd0))
    else $error("offset reported without a match");

  a_no_ram_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(d_we && d_re) && !(s_we && s_re))
    else $error("memory read and write in the same cycle");

endmodule

@@ verif/record_layout_validator_core_test.sv @@
module record_layout_validator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlv_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 8;
  // Watchdog limit on the total run length.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Idle tail after the run; it outlasts the longest attribute scan.
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_EVERY  = 250;
  // The block ignores this kind apart from reporting the status.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One input beat, plus a flag that makes the driver wait for an empty pipe first.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] buffer_size;
    logic [31:0] record_count;
    logic [15:0] entry_count;
    logic [15:0] record_bytes;
    logic [15:0] name_hash;
    logic [15:0] field_offset;
    logic [31:0] field_bytes;
    logic        required;
    bit          hold_for_drain;
  } layout_beat_t;

  // One result beat as the block should report it.
  typedef struct {
    logic        valid_res;
    err_t        error_code;
    logic        found;
    logic [15:0] found_offset;
  } layout_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_HDR;
  logic [31:0] in_buffer_size = '0;
  logic [31:0] in_record_count = '0;
  logic [15:0] in_entry_count = '0;
  logic [15:0] in_record_bytes = '0;
  logic [15:0] in_name_hash = '0;
  logic [15:0] in_field_offset = '0;
  logic [31:0] in_field_bytes = '0;
  logic        in_required = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_valid_res;
  logic [3:0]  out_error_code;
  logic        out_found;
  logic [15:0] out_found_offset;

  layout_beat_t    pending_beats[$];
  layout_verdict_t expected_verdicts[$];
  layout_beat_t    beat_on_wire;
  layout_verdict_t verdict_due;

  int  fail_count   = 0;
  int  cycle_count  = 0;
  int  queued_items = 0;
  bit  drain_next   = 1'b0;
  int  send_gap     = 0;
  int  send_calm    = 0;
  int  recv_stall   = 0;
  int  recv_calm    = 0;

  // Shadow of the layout checker: descriptor table, found-attribute list, status.
  logic [15:0] shadow_desc_hash[MAX_DESCRIPTORS];
  logic [15:0] shadow_desc_off[MAX_DESCRIPTORS];
  int          shadow_desc_count = 0;
  logic [15:0] shadow_seen_beg[MAX_EXPECTED];
  logic [15:0] shadow_seen_len[MAX_EXPECTED];
  int          shadow_seen_count = 0;
  logic [15:0] shadow_rec_bytes = '0;
  bit          shadow_has_records = 1'b0;
  err_t        shadow_fault = ERR_NONE;

  record_layout_validator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_buffer_size   (in_buffer_size),
    .in_record_count  (in_record_count),
    .in_entry_count   (in_entry_count),
    .in_record_bytes  (in_record_bytes),
    .in_name_hash     (in_name_hash),
    .in_field_offset  (in_field_offset),
    .in_field_bytes   (in_field_bytes),
    .in_required      (in_required),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_error_code   (out_error_code),
    .out_found        (out_found),
    .out_found_offset (out_found_offset)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Keep only the first failure since the last header.
  function automatic void raise_fault(err_t code);
    if (shadow_fault == ERR_NONE) begin
      shadow_fault = code;
    end
  endfunction

  // Advance the shadow state by one accepted beat and return the result it owes.
  function automatic layout_verdict_t predict_verdict(layout_beat_t b);
    layout_verdict_t v;
    logic [31:0] hdr_len;
    logic [63:0] rec_span;
    logic [31:0] room;
    logic [15:0] hit_off;
    bit          hit;
    bit          clash;
    hit     = 1'b0;
    hit_off = '0;
    clash   = 1'b0;
    if (b.kind == KIND_HDR) begin
      // A header starts a fresh check: clear both tables and the status.
      shadow_desc_count  = 0;
      shadow_seen_count  = 0;
      shadow_fault       = ERR_NONE;
      shadow_rec_bytes   = b.record_bytes;
      shadow_has_records = (b.record_count != 0);
      hdr_len  = {16'd0, b.entry_count} * HDR_WORD_BYTES + HDR_WORD_BYTES;
      rec_span = {32'd0, b.record_count} * {48'd0, b.record_bytes};
      if (b.buffer_size < 32'd4) begin
        raise_fault(ERR_SMALL_BUF);
      end else begin
        if (hdr_len > b.buffer_size) raise_fault(ERR_HDR_OVF);
        if (b.record_count != 0 && b.record_bytes == 0) raise_fault(ERR_ZERO_REC);
        // Skip the records test once the header alone overruns the buffer.
        if (hdr_len <= b.buffer_size && rec_span > {32'd0, b.buffer_size - hdr_len}) begin
          raise_fault(ERR_REC_OVF);
        end
      end
    end else if (b.kind == KIND_DESC) begin
      if (shadow_desc_count >= MAX_DESCRIPTORS) begin
        // Table is full: drop the descriptor.
        raise_fault(ERR_TABLE_FULL);
      end else begin
        shadow_desc_hash[shadow_desc_count] = b.name_hash;
        shadow_desc_off[shadow_desc_count]  = b.field_offset;
        shadow_desc_count++;
        if (b.field_offset > shadow_rec_bytes) raise_fault(ERR_DESC_OFS);
      end
    end else if (b.kind == KIND_ATTR) begin
      // First matching descriptor wins.
      for (int i = 0; i < shadow_desc_count; i++) begin
        if (!hit && shadow_desc_hash[i] == b.name_hash) begin
          hit     = 1'b1;
          hit_off = shadow_desc_off[i];
        end
      end
      if (!hit) begin
        if (b.required && shadow_has_records) raise_fault(ERR_MISSING_REQ);
      end else begin
        room = {16'd0, shadow_rec_bytes} - {16'd0, hit_off};
        if (hit_off > shadow_rec_bytes || b.field_bytes > room) begin
          raise_fault(ERR_ATTR_OUT);
        end else begin
          // Fitting span, so hit_off + field_bytes stays within 16 bits.
          for (int i = 0; i < shadow_seen_count; i++) begin
            if ({16'd0, hit_off} < {16'd0, shadow_seen_beg[i]} + {16'd0, shadow_seen_len[i]} &&
                {16'd0, shadow_seen_beg[i]} < {16'd0, hit_off} + b.field_bytes) begin
              clash = 1'b1;
            end
          end
          if (clash) begin
            raise_fault(ERR_OVERLAP);
          end else if (shadow_seen_count >= MAX_EXPECTED) begin
            raise_fault(ERR_LIST_FULL);
          end else begin
            shadow_seen_beg[shadow_seen_count] = hit_off;
            shadow_seen_len[shadow_seen_count] = b.field_bytes[15:0];
            shadow_seen_count++;
          end
        end
      end
    end
    v.valid_res    = (shadow_fault == ERR_NONE);
    v.error_code   = shadow_fault;
    v.found        = hit;
    v.found_offset = hit ? hit_off : 16'd0;
    return v;
  endfunction

  // Mostly no pause, else short ones, a few long ones, and now and then a calm stretch of none.
  function automatic int pick_pause(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fill every field with noise; the kind decides which ones the block looks at.
  function automatic layout_beat_t junk_beat(logic [1:0] kind);
    layout_beat_t b;
    b.kind           = kind;
    b.buffer_size    = $urandom();
    b.record_count   = $urandom();
    b.entry_count    = 16'($urandom());
    b.record_bytes   = 16'($urandom());
    b.name_hash      = 16'($urandom());
    b.field_offset   = 16'($urandom());
    b.field_bytes    = $urandom();
    b.required       = 1'($urandom_range(0, 1));
    b.hold_for_drain = 1'b0;
    return b;
  endfunction

  // Buffer size that just holds header and records plus slack, saturated at 32 bits.
  function automatic logic [31:0] fit_buffer(logic [31:0] count, int entries,
                                             logic [15:0] rb, int slack);
    logic [63:0] total;
    total = 64'(entries) * HDR_WORD_BYTES + HDR_WORD_BYTES +
            {32'd0, count} * {48'd0, rb} + 64'(slack);
    return (total > 64'hffff_ffff) ? 32'hffff_ffff : total[31:0];
  endfunction

  task automatic push_beat(layout_beat_t b);
    b.hold_for_drain = drain_next;
    drain_next = 1'b0;
    pending_beats.push_back(b);
    if (b.kind != KIND_UNUSED) queued_items++;
  endtask

  task automatic add_header(logic [31:0] size, logic [31:0] count,
                            logic [15:0] entries, logic [15:0] rb);
    layout_beat_t b;
    b = junk_beat(KIND_HDR);
    b.buffer_size  = size;
    b.record_count = count;
    b.entry_count  = entries;
    b.record_bytes = rb;
    push_beat(b);
  endtask

  task automatic add_desc(logic [15:0] hash, logic [15:0] off);
    layout_beat_t b;
    b = junk_beat(KIND_DESC);
    b.name_hash    = hash;
    b.field_offset = off;
    push_beat(b);
  endtask

  task automatic add_attr(logic [15:0] hash, logic [31:0] len, logic req);
    layout_beat_t b;
    b = junk_beat(KIND_ATTR);
    b.name_hash   = hash;
    b.field_bytes = len;
    b.required    = req;
    push_beat(b);
  endtask

  // Plausible layout: header sized to fit, spaced descriptors, attributes mostly hitting.
  task automatic add_layout_session();
    int          nd;
    int          na;
    int          stride;
    int          pick;
    int          r;
    int          off;
    logic [15:0] rb;
    logic [15:0] base;
    logic [15:0] hash;
    logic [31:0] count;
    logic [31:0] size;
    logic [31:0] len;
    r  = $urandom_range(0, 9);
    rb = (r < 7) ? 16'($urandom_range(1, 512)) :
         (r < 9) ? 16'($urandom_range(1, 65535)) : 16'd0;
    r     = $urandom_range(0, 9);
    count = (r < 6) ? 32'($urandom_range(1, 8)) : (r < 8) ? 32'd0 : 32'($urandom());
    nd    = $urandom_range(0, 12);
    na    = $urandom_range(0, 10);
    size  = fit_buffer(count, nd, rb,
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 64));
    // Now and then come up one byte short.
    if ($urandom_range(0, 15) == 0) size = size - 32'd1;
    add_header(size, count, 16'(nd), rb);
    base   = 16'($urandom());
    stride = (nd > 0) ? int'(rb) / nd : int'(rb);
    for (int i = 0; i < nd; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        off = int'(rb) + $urandom_range(0, 3);
        add_desc(base + 16'(i), 16'(off));
      end else if (r < 3 && i > 0) begin
        // Repeat the previous hash; the earlier entry must win the lookup.
        add_desc(base + 16'(i - 1), 16'(i * stride));
      end else begin
        add_desc(base + 16'(i), 16'(i * stride));
      end
    end
    for (int j = 0; j < na; j++) begin
      r    = $urandom_range(0, 15);
      pick = (nd > 0) ? $urandom_range(0, nd - 1) : 0;
      hash = (r < 2 || nd == 0) ? 16'($urandom()) : base + 16'(pick);
      r    = $urandom_range(0, 15);
      len  = (r < 12) ? 32'($urandom_range(0, stride)) :
             (r < 15) ? 32'($urandom_range(0, int'(rb) + 8)) : 32'($urandom());
      add_attr(hash, len, 1'($urandom_range(0, 1)));
    end
  endtask

  // Fill the descriptor table to around its capacity, often past it.
  task automatic add_table_flood();
    int          nd;
    logic [15:0] base;
    nd   = $urandom_range(MAX_DESCRIPTORS - 4, MAX_DESCRIPTORS + 6);
    base = 16'($urandom());
    add_header(fit_buffer(32'd1, nd, 16'hffff, 0), 32'd1, 16'(nd), 16'hffff);
    for (int i = 0; i < nd; i++) add_desc(base + 16'(i), 16'($urandom_range(0, 65535)));
    repeat (3) add_attr(base + 16'($urandom_range(0, nd - 1)), $urandom_range(0, 16), 1'b1);
  endtask

  // Non-overlapping hits around the capacity of the found-attribute list.
  task automatic add_list_flood();
    int          na;
    logic [15:0] base;
    logic [31:0] count;
    na    = $urandom_range(MAX_EXPECTED - 2, MAX_EXPECTED + 4);
    base  = 16'($urandom());
    count = $urandom_range(1, 4);
    add_header(fit_buffer(count, na + 2, 16'hffff, 16), count, 16'(na + 2), 16'hffff);
    for (int i = 0; i < na + 2; i++) add_desc(base + 16'(i), 16'(i * 64));
    for (int j = 0; j < na; j++) add_attr(base + 16'(j), $urandom_range(0, 64),
                                          1'($urandom_range(0, 1)));
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Driver: present pending beats, hold each until accepted, predict on accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(predict_verdict(beat_on_wire));
      end
      // Only touch the payload once the current beat is gone.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold_for_drain && expected_verdicts.size() != 0)) begin
          beat_on_wire     = pending_beats.pop_front();
          in_kind         <= beat_on_wire.kind;
          in_buffer_size  <= beat_on_wire.buffer_size;
          in_record_count <= beat_on_wire.record_count;
          in_entry_count  <= beat_on_wire.entry_count;
          in_record_bytes <= beat_on_wire.record_bytes;
          in_name_hash    <= beat_on_wire.name_hash;
          in_field_offset <= beat_on_wire.field_offset;
          in_field_bytes  <= beat_on_wire.field_bytes;
          in_required     <= beat_on_wire.required;
          in_valid        <= 1'b1;
          send_gap         = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side at random and check each result beat in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $error("result beat arrived with no prediction pending");
        end else begin
          verdict_due = expected_verdicts.pop_front();
          check_field("valid_res", 32'(verdict_due.valid_res), 32'(out_valid_res));
          check_field("error_code", 32'(verdict_due.error_code), 32'(out_error_code));
          check_field("found", 32'(verdict_due.found), 32'(out_found));
          check_field("found_offset", 32'(verdict_due.found_offset),
                      32'(out_found_offset));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = pick_pause(recv_calm);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int r;
    int next_drain;
    // Beats ahead of any header run against the reset state.
    add_desc(16'h1234, 16'd0);
    add_attr(16'h1234, 32'd0, 1'b1);
    add_attr(16'hffff, 32'd1, 1'b1);
    push_beat(junk_beat(KIND_UNUSED));
    // Header bounds: tiny buffers, exact minimum, header overrun, all-ones, empty records.
    add_header(32'd0, 32'd1, 16'd0, 16'd8);
    add_header(32'd3, 32'd0, 16'd0, 16'd0);
    add_header(32'd4, 32'd0, 16'd0, 16'd0);
    add_header(32'd4, 32'd1, 16'd1, 16'd0);
    add_header(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    add_header(32'hffff_ffff, 32'd1, 16'd0, 16'd0);
    // Exact fit; duplicate hash, offset at the record end, adjoining spans, then overlap.
    add_header(32'd220, 32'd2, 16'd4, 16'd100);
    add_desc(16'ha000, 16'd0);
    add_desc(16'ha001, 16'd10);
    add_desc(16'ha000, 16'd50);
    add_desc(16'hffff, 16'd100);
    add_attr(16'ha000, 32'd10, 1'b1);
    add_attr(16'ha001, 32'd90, 1'b0);
    add_attr(16'hffff, 32'd0, 1'b0);
    add_attr(16'ha001, 32'd4, 1'b0);
    // Descriptor past the record end.
    add_header(32'd220, 32'd2, 16'd4, 16'd100);
    add_desc(16'h0001, 16'd101);
    // Required attribute missing while records exist.
    add_header(32'd220, 32'd2, 16'd4, 16'd100);
    add_attr(16'h7777, 32'd1, 1'b1);
    // Attribute running off the record end, then the widest size.
    add_header(32'd208, 32'd2, 16'd1, 16'd100);
    add_desc(16'h0002, 16'd90);
    add_attr(16'h0002, 32'd11, 1'b0);
    add_attr(16'h0002, 32'hffff_ffff, 1'b0);
    // Hold the first random beat until the directed part has fully drained.
    drain_next = 1'b1;
    next_drain = queued_items + DRAIN_EVERY;
    add_table_flood();
    add_list_flood();
    while (queued_items < RANDOM_ITEMS) begin
      if (queued_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain = queued_items + DRAIN_EVERY;
      end
      r = $urandom_range(0, 19);
      if (r < 2) begin
        repeat ($urandom_range(1, 4)) push_beat(junk_beat(2'($urandom_range(0, 3))));
      end else if (r == 2) begin
        add_table_flood();
      end else if (r == 3) begin
        add_list_flood();
      end else if (r < 6) begin
        push_beat(junk_beat(KIND_HDR));
        repeat ($urandom_range(0, 3)) push_beat(junk_beat(2'($urandom_range(1, 2))));
      end else begin
        add_layout_session();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every beat is in and every result is out, then let stragglers show.
    while (pending_beats.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      fail_count++;
      $error("result beats missing: %0d predictions left", expected_verdicts.size());
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
